// ===== src/i2r_pkg.sv =====
// Shared types, constants and letter tables for the integer to Roman numeral core.
// No dependencies; used by every module under src.
package i2r_pkg;

  localparam int VALUE_W     = 12;
  localparam int VALUE_MAX   = 3999;
  localparam int SYMBOL_W    = 8;
  localparam int QUEUE_DEPTH = 2;
  // wide enough for 9 * 1000 during the digit split
  localparam int SPLIT_W     = 14;

  localparam logic [SYMBOL_W-1:0] ASCII_I = 8'h49;
  localparam logic [SYMBOL_W-1:0] ASCII_V = 8'h56;
  localparam logic [SYMBOL_W-1:0] ASCII_X = 8'h58;
  localparam logic [SYMBOL_W-1:0] ASCII_L = 8'h4C;
  localparam logic [SYMBOL_W-1:0] ASCII_C = 8'h43;
  localparam logic [SYMBOL_W-1:0] ASCII_D = 8'h44;
  localparam logic [SYMBOL_W-1:0] ASCII_M = 8'h4D;

  // Decimal positions, ones up to thousands
  localparam logic [1:0] POS_ONES      = 2'd0;
  localparam logic [1:0] POS_TENS      = 2'd1;
  localparam logic [1:0] POS_HUNDREDS  = 2'd2;
  localparam logic [1:0] POS_THOUSANDS = 2'd3;

  typedef enum logic [1:0] {
    SEL_ONES,
    SEL_FIVE,
    SEL_NEXT
  } letter_sel_t;

  // One classified item: error flag or four decimal digits
  typedef struct packed {
    logic             err;
    logic [3:0][3:0]  digit;  // digit[3] = thousands
  } entry_t;

  function automatic logic [SPLIT_W-1:0] step_radix(input logic [1:0] step);
    logic [SPLIT_W-1:0] r;
    unique case (step)
      2'd0:    r = SPLIT_W'(1000);
      2'd1:    r = SPLIT_W'(100);
      default: r = SPLIT_W'(10);
    endcase
    return r;
  endfunction

  // Number of letters a digit needs (0..4)
  function automatic logic [2:0] digit_len(input logic [3:0] d);
    logic [2:0] n;
    unique case (d)
      4'd1, 4'd5:        n = 3'd1;
      4'd2, 4'd4, 4'd6,
      4'd9:              n = 3'd2;
      4'd3, 4'd7:        n = 3'd3;
      4'd8:              n = 3'd4;
      default:           n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic letter_sel_t letter_sel(input logic [3:0] d, input logic [1:0] k);
    letter_sel_t s;
    unique case (d)
      4'd4:              s = (k == 2'd0) ? SEL_ONES : SEL_FIVE;
      4'd5, 4'd6, 4'd7,
      4'd8:              s = (k == 2'd0) ? SEL_FIVE : SEL_ONES;
      4'd9:              s = (k == 2'd0) ? SEL_ONES : SEL_NEXT;
      default:           s = SEL_ONES;
    endcase
    return s;
  endfunction

  function automatic logic [SYMBOL_W-1:0] roman_letter(input logic [1:0] pos,
                                                       input letter_sel_t sel);
    logic [SYMBOL_W-1:0] c;
    unique case (pos)
      POS_ONES: begin
        c = (sel == SEL_ONES) ? ASCII_I : (sel == SEL_FIVE) ? ASCII_V : ASCII_X;
      end
      POS_TENS: begin
        c = (sel == SEL_ONES) ? ASCII_X : (sel == SEL_FIVE) ? ASCII_L : ASCII_C;
      end
      POS_HUNDREDS: begin
        c = (sel == SEL_ONES) ? ASCII_C : (sel == SEL_FIVE) ? ASCII_D : ASCII_M;
      end
      default: begin
        c = ASCII_M;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== src/i2r_front.sv =====
// Input side: accepts a value, range checks it and splits it into decimal digits.
// Depends on i2r_pkg.
module i2r_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [i2r_pkg::VALUE_W-1:0] in_value,
  output logic                   push_valid,
  input  logic                   push_ready,
  output i2r_pkg::entry_t        push_data
);
  import i2r_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SPLIT,
    F_PUSH
  } state_t;

  state_t             state;
  logic [1:0]         step;
  logic [VALUE_W-1:0] rem;
  entry_t             entry;

  logic [SPLIT_W-1:0] radix;
  logic [3:0]         q;
  logic [SPLIT_W-1:0] rem_sub;
  logic [VALUE_W-1:0] rem_next;

  // One digit per cycle: parallel compares against 1..9 times the radix
  always_comb begin
    radix = step_radix(step);
    q     = 4'd0;
    for (int j = 1; j <= 9; j++) begin
      if ({{(SPLIT_W-VALUE_W){1'b0}}, rem} >= SPLIT_W'(j) * radix) begin
        q = 4'(j);
      end
    end
    rem_sub  = {{(SPLIT_W-VALUE_W){1'b0}}, rem} - SPLIT_W'(q) * radix;
    rem_next = rem_sub[VALUE_W-1:0];
  end

  assign in_ready   = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);
  assign push_data  = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= 2'd0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            entry.digit <= '0;
            if (in_value == '0 || in_value > VALUE_W'(VALUE_MAX)) begin
              entry.err <= 1'b1;
              state     <= F_PUSH;
            end else begin
              entry.err <= 1'b0;
              rem       <= in_value;
              step      <= 2'd0;
              state     <= F_SPLIT;
            end
          end
        end
        F_SPLIT: begin
          entry.digit[2'(2'd3 - step)] <= q;
          rem  <= rem_next;
          step <= step + 2'd1;
          if (step == 2'd2) begin
            entry.digit[0] <= rem_next[3:0];
            state          <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/i2r_fifo.sv =====
// Short register queue carrying classified items from the front to the back.
// Depends on i2r_pkg for the entry type.
module i2r_fifo #(
  parameter int DEPTH = i2r_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  i2r_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output i2r_pkg::entry_t pop_data
);
  import i2r_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/i2r_back.sv =====
// Output side: walks the digits of one item and emits one letter per beat.
// Depends on i2r_pkg for the entry type and the letter tables.
module i2r_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  i2r_pkg::entry_t             pop_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [i2r_pkg::SYMBOL_W-1:0] out_symbol,
  output logic                        out_last,
  output logic                        out_error
);
  import i2r_pkg::*;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } state_t;

  state_t      state;
  entry_t      entry;
  logic [1:0]  pos;
  logic [1:0]  k;

  logic [3:0]  cur;
  logic [2:0]  len;
  logic        digit_done;
  logic        lower_zero;
  logic        slot_free;
  logic        emit;
  logic [SYMBOL_W-1:0] sym;

  always_comb begin
    cur        = entry.digit[pos];
    len        = digit_len(cur);
    digit_done = ({1'b0, k} == len - 3'd1);
    sym        = roman_letter(pos, letter_sel(cur, k));
    unique case (pos)
      POS_THOUSANDS: lower_zero = (entry.digit[2] == '0) && (entry.digit[1] == '0)
                                  && (entry.digit[0] == '0);
      POS_HUNDREDS:  lower_zero = (entry.digit[1] == '0) && (entry.digit[0] == '0);
      POS_TENS:      lower_zero = (entry.digit[0] == '0);
      default:       lower_zero = 1'b1;
    endcase
  end

  assign slot_free = !out_valid || out_ready;
  assign pop_ready = (state == B_IDLE);
  // a beat is loaded into the output register this cycle: error beat or a letter of a nonempty digit
  assign emit      = (state == B_RUN) && slot_free && (entry.err || (len != 3'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      pos       <= POS_THOUSANDS;
      k         <= 2'd0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (pop_valid) begin
            entry <= pop_data;
            pos   <= POS_THOUSANDS;
            k     <= 2'd0;
            state <= B_RUN;
          end
        end
        B_RUN: begin
          if (slot_free) begin
            if (entry.err) begin
              out_symbol <= '0;
              out_last   <= 1'b1;
              out_error  <= 1'b1;
              state      <= B_IDLE;
            end else if (len == 3'd0) begin
              // empty digit: step to the next position without a beat
              pos <= pos - 2'd1;
            end else begin
              out_symbol <= sym;
              out_error  <= 1'b0;
              out_last   <= digit_done && lower_zero;
              if (digit_done) begin
                k   <= 2'd0;
                pos <= pos - 2'd1;
                if (lower_zero) begin
                  state <= B_IDLE;
                end
              end else begin
                k <= k + 2'd1;
              end
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/integer_to_roman_numeral_core.sv =====
// Integer to Roman numeral converter. Each input beat carries a value; for 1..3999
// the core sends the numeral as one ASCII letter per output beat, most significant
// first, with tlast on the final letter and tuser low. A value of 0 or above 3999
// gives a single beat with tdata zero, tlast and tuser high. The front takes a value,
// splits it into decimal digits in its split state and offers it to the queue from
// its push state, so it takes no new beat until the item is pushed (an out-of-range
// value skips the split). The back loads an item while idle, then emits one letter
// per cycle unless the output stalls (1 to 15 letters), stepping past each zero digit
// ahead of the last nonzero digit without a beat; the slower side sets the sustained rate.
// Depends on i2r_pkg, i2r_front, i2r_fifo and i2r_back.
module integer_to_roman_numeral_core #(
  parameter int QUEUE_DEPTH = i2r_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] value, [15:12] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] symbol
  output logic        m_tlast,
  output logic        m_tuser    // [0] error
);
  import i2r_pkg::*;

  entry_t push_data;
  entry_t pop_data;
  logic   push_valid;
  logic   push_ready;
  logic   pop_valid;
  logic   pop_ready;

  i2r_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_value   (s_tdata[VALUE_W-1:0]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  i2r_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  i2r_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_symbol (m_tdata),
    .out_last   (m_tlast),
    .out_error  (m_tuser)
  );

endmodule

// ===== dv/roman_checker.sv =====
`timescale 1ns / 100ps
// Checker for integer_to_roman_numeral_core: watches both stream channels, predicts
// the numeral for every accepted value and compares each output beat in order.
// Depends on i2r_pkg for widths, the value limit and the ASCII letter codes.
module roman_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [15:0]                  s_tdata,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [i2r_pkg::SYMBOL_W-1:0] m_tdata,
  input  logic                         m_tlast,
  input  logic                         m_tuser,
  output int                           fail_count,
  output int                           pending
);
  import i2r_pkg::*;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
    logic                error;
  } letter_beat_t;

  // Letters per decimal position, ones position in the low byte.
  // Padded so the next-ones lookup never runs off the end.
  localparam logic [5*SYMBOL_W-1:0] ONES_LETTERS =
    {ASCII_M, ASCII_M, ASCII_C, ASCII_X, ASCII_I};
  localparam logic [4*SYMBOL_W-1:0] FIVE_LETTERS =
    {8'h00, ASCII_D, ASCII_L, ASCII_V};

  letter_beat_t numeral_q[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= 100) begin
      $display("[%0t] mismatch on %s: got 'h%0h, expected 'h%0h", $time, what, got, want);
    end
  endtask

  task automatic queue_numeral(input logic [VALUE_W-1:0] value);
    logic [SYMBOL_W-1:0] letters[$];
    logic [SYMBOL_W-1:0] one;
    logic [SYMBOL_W-1:0] five;
    logic [SYMBOL_W-1:0] next;
    int unsigned         scale;
    int unsigned         d;
    letter_beat_t        b;
    if (value == 0 || value > VALUE_MAX) begin
      b.symbol = '0;
      b.last   = 1'b1;
      b.error  = 1'b1;
      numeral_q.push_back(b);
      return;
    end
    scale = 1000;
    for (int p = 3; p >= 0; p--) begin
      d    = (value / scale) % 10;
      one  = ONES_LETTERS[p*SYMBOL_W +: SYMBOL_W];
      five = FIVE_LETTERS[p*SYMBOL_W +: SYMBOL_W];
      next = ONES_LETTERS[(p+1)*SYMBOL_W +: SYMBOL_W];
      case (d)
        1, 2, 3: begin
          repeat (d) letters.push_back(one);
        end
        4: begin
          letters.push_back(one);
          letters.push_back(five);
        end
        5, 6, 7, 8: begin
          letters.push_back(five);
          repeat (d - 5) letters.push_back(one);
        end
        9: begin
          letters.push_back(one);
          letters.push_back(next);
        end
        default: begin
        end
      endcase
      scale = scale / 10;
    end
    foreach (letters[k]) begin
      b.symbol = letters[k];
      b.last   = (k == letters.size() - 1);
      b.error  = 1'b0;
      numeral_q.push_back(b);
    end
  endtask

  always @(posedge clk) begin : monitor
    letter_beat_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        queue_numeral(s_tdata[VALUE_W-1:0]);
      end
      if (m_tvalid && m_tready) begin
        if (numeral_q.size() == 0) begin
          report_mismatch("beat with nothing expected", m_tdata, 0);
        end else begin
          want = numeral_q.pop_front();
          if (m_tdata !== want.symbol) report_mismatch("symbol", m_tdata, want.symbol);
          if (m_tlast !== want.last)   report_mismatch("last", m_tlast, want.last);
          if (m_tuser !== want.error)  report_mismatch("error", m_tuser, want.error);
        end
      end
      pending <= numeral_q.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the integer to Roman numeral testbench: clock, reset, value stimulus and
// output back-pressure. Depends on i2r_pkg, the core under src and roman_checker.
module testbench;
  import i2r_pkg::*;

  localparam int RANDOM_VALUES = 480;
  localparam int TAIL_CYCLES   = 40;
  // worst item: longest input gap, longest stall ahead of each of 15 letters, front and queue
  localparam int CYCLE_LIMIT   = 600000;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [15:0]         s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [SYMBOL_W-1:0] m_tdata;
  logic                m_tlast;
  logic                m_tuser;

  int fail_count;
  int pending;
  int cycles;
  bit send_quiet;
  bit recv_quiet;

  int directed_values[24] = '{0, 4095, 4000, 3999, 1, 3888, 4, 9, 40, 90, 400, 900,
                              5, 50, 500, 8, 80, 800, 3000, 1994, 2649, 1004, 2048, 3};

  integer_to_roman_numeral_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  roman_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return VALUE_W'($urandom_range(1, VALUE_MAX));
    if (r < 78) return VALUE_W'($urandom_range(1, 99));
    if (r < 88) return VALUE_W'($urandom_range(VALUE_MAX + 1, 4095));
    if (r < 91) return '0;
    return VALUE_W'($urandom_range(0, 4095));
  endfunction

  // Holds the beat until the core takes it; tvalid stays up across back-to-back beats.
  task automatic send_value(input logic [VALUE_W-1:0] value);
    int gap;
    if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(16-VALUE_W){1'b0}}, value};
    do @(posedge clk); while (!s_tready);
  endtask

  // Output back-pressure: a fresh random stall, possibly none, ahead of every output beat
  initial begin
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 59) == 0) recv_quiet = !recv_quiet;
      stall = recv_quiet ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_values[i]) send_value(VALUE_W'(directed_values[i]));
    repeat (RANDOM_VALUES) send_value(pick_value());
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
